[design/bracket_range_balance_checker_unit_macros.svh]
// Assertion macros used by the port level checker of the bracket range balance checker.
`ifndef BRACKET_RANGE_BALANCE_CHECKER_UNIT_MACROS_SVH
`define BRACKET_RANGE_BALANCE_CHECKER_UNIT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define BRBC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define BRBC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/brbc_pkg.sv]
// Package with the beat types, command and status structs of the bracket range balance checker.
package brbc_pkg;

	localparam int RANGE_W = 11;

	typedef struct packed {
		logic               mode;
		logic               is_open;
		logic [RANGE_W-1:0] range_start;
		logic [RANGE_W-1:0] range_end;
	} in_t;

	typedef struct packed {
		logic balanced;
		logic bad_range;
	} out_t;

	typedef struct packed {
		logic clr;
		logic capture;
		logic ld_leaf;
		logic ld_sib;
		logic ld_up;
		logic dep_base;
		logic dep_end;
		logic walk;
		logic res_bad;
		logic res_eval;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic full;
		logic bad;
		logic top;
		logic walk_done;
	} sts_t;

endpackage

[design/brbc_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module brbc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/brbc_ctrl.sv]
// Controller state machine that sequences clearing, loads and queries.
module brbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  brbc_pkg::sts_t sts,
	output brbc_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_LD    = 4'd2;
	localparam logic [3:0] S_LSIB  = 4'd3;
	localparam logic [3:0] S_LUP   = 4'd4;
	localparam logic [3:0] S_QB    = 4'd5;
	localparam logic [3:0] S_QE    = 4'd6;
	localparam logic [3:0] S_QWALK = 4'd7;
	localparam logic [3:0] S_QFIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (!mode) begin
						if (!sts.full) begin
							state_d = S_LD;
						end
					end else if (sts.bad) begin
						cmd.res_bad = 1'b1;
					end else begin
						state_d = S_QB;
					end
				end
			end
			S_LD: begin
				cmd.ld_leaf = 1'b1;
				state_d     = S_LSIB;
			end
			S_LSIB: begin
				if (sts.top) begin
					state_d = S_IDLE;
				end else begin
					cmd.ld_sib = 1'b1;
					state_d    = S_LUP;
				end
			end
			S_LUP: begin
				cmd.ld_up = 1'b1;
				state_d   = S_LSIB;
			end
			S_QB: begin
				cmd.dep_base = 1'b1;
				cmd.walk     = 1'b1;
				state_d      = S_QE;
			end
			S_QE: begin
				cmd.dep_end = 1'b1;
				cmd.walk    = 1'b1;
				state_d     = S_QWALK;
			end
			S_QWALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = S_QFIN;
				end
			end
			S_QFIN: begin
				cmd.res_eval = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/brbc_dp.sv]
// Datapath with the depth memory, the min tree memory, the tree walkers and the result register.
module brbc_dp #(
	parameter int MAX_LENGTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  brbc_pkg::in_t   item,
	input  brbc_pkg::cmd_t  cmd,
	output brbc_pkg::sts_t  sts,
	output logic            result_valid,
	output brbc_pkg::out_t  result
);

	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int DW = CW + 1;
	localparam int TW = $clog2(2 * MAX_LENGTH);
	localparam int LW = TW + 1;
	localparam int RW = brbc_pkg::RANGE_W;
	localparam int WW = ((LW > RW) ? LW : RW) + 1;
	localparam logic signed [DW-1:0] DEPTH_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [TW-1:0] LEAF_BASE = TW'(MAX_LENGTH);
	localparam logic [TW-1:0] LAST_IDX = TW'(2 * MAX_LENGTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LENGTH);

	logic [CW-1:0]        count_q;
	logic signed [DW-1:0] last_q;
	logic [TW-1:0]        clr_idx_q;
	logic                 is_open_q;
	logic [RW-1:0]        x_q;
	logic [RW-1:0]        y_q;
	logic [TW-1:0]        cur_idx_q;
	logic signed [DW-1:0] cur_val_q;
	logic [LW-1:0]        l_q;
	logic [LW-1:0]        r_q;
	logic signed [DW-1:0] m_q;
	logic                 tr_pend_q;
	logic                 db_pend_q;
	logic                 de_pend_q;
	logic signed [DW-1:0] base_q;
	logic signed [DW-1:0] end_q;
	logic                 res_valid_q;
	brbc_pkg::out_t       res_q;

	logic [WW-1:0]        x_w;
	logic [WW-1:0]        y_w;
	logic [WW-1:0]        cnt_w;
	logic [WW-1:0]        l_init_w;
	logic [WW-1:0]        r_init_w;
	logic [WW-1:0]        xq_m1_w;
	logic [WW-1:0]        yq_w;
	logic signed [DW-1:0] step_v;
	logic signed [DW-1:0] ld_val;
	logic [TW-1:0]        leaf_idx;
	logic [TW-1:0]        par_idx;
	logic [DW-1:0]        tr_rdata;
	logic signed [DW-1:0] tr_rd;
	logic signed [DW-1:0] up_val;
	logic [DW-1:0]        dep_rdata;
	logic [LW-1:0]        l_inc;
	logic [LW-1:0]        r_dec;
	logic                 walk_done;
	logic                 walk_rd;

	logic          tr_we;
	logic [TW-1:0] tr_waddr;
	logic [DW-1:0] tr_wdata;
	logic [TW-1:0] tr_raddr;
	logic          dep_we;
	logic [CW-1:0] dep_waddr;
	logic [DW-1:0] dep_wdata;
	logic [CW-1:0] dep_raddr;

	assign x_w      = WW'(item.range_start);
	assign y_w      = WW'(item.range_end);
	assign cnt_w    = WW'(count_q);
	assign l_init_w = WW'(MAX_LENGTH) + x_w - WW'(1);
	assign r_init_w = WW'(MAX_LENGTH) + y_w;
	assign xq_m1_w  = WW'(x_q) - WW'(1);
	assign yq_w     = WW'(y_q);

	assign step_v   = is_open_q ? {{(DW-1){1'b0}}, 1'b1} : {DW{1'b1}};
	assign ld_val   = last_q + step_v;
	assign leaf_idx = LEAF_BASE + TW'(count_q);
	assign par_idx  = cur_idx_q >> 1;
	assign tr_rd    = $signed(tr_rdata);
	assign up_val   = (cur_val_q < tr_rd) ? cur_val_q : tr_rd;
	assign l_inc    = l_q + LW'(1);
	assign r_dec    = r_q - LW'(1);
	assign walk_done = (l_q >= r_q);
	assign walk_rd  = cmd.walk && !walk_done && (l_q[0] || r_q[0]);

	assign sts.clr_last  = (clr_idx_q == LAST_IDX);
	assign sts.full      = (count_q == FULL_CNT);
	assign sts.bad       = (x_w == '0) || (x_w > y_w) || (y_w > cnt_w);
	assign sts.top       = (cur_idx_q == TW'(1));
	assign sts.walk_done = walk_done;

	always_comb begin
		tr_we    = 1'b0;
		tr_waddr = clr_idx_q;
		tr_wdata = DEPTH_MAX;
		if (cmd.clr) begin
			tr_we = 1'b1;
		end else if (cmd.ld_leaf) begin
			tr_we    = 1'b1;
			tr_waddr = leaf_idx;
			tr_wdata = ld_val;
		end else if (cmd.ld_up) begin
			tr_we    = 1'b1;
			tr_waddr = par_idx;
			tr_wdata = up_val;
		end
	end

	always_comb begin
		tr_raddr = cur_idx_q ^ TW'(1);
		if (cmd.walk) begin
			if (l_q[0]) begin
				tr_raddr = l_q[TW-1:0];
			end else begin
				tr_raddr = r_dec[TW-1:0];
			end
		end
	end

	always_comb begin
		dep_we    = 1'b0;
		dep_waddr = '0;
		dep_wdata = '0;
		if (cmd.clr) begin
			dep_we = 1'b1;
		end else if (cmd.ld_leaf) begin
			dep_we    = 1'b1;
			dep_waddr = count_q + CW'(1);
			dep_wdata = ld_val;
		end
	end

	assign dep_raddr = cmd.dep_base ? xq_m1_w[CW-1:0] : yq_w[CW-1:0];

	brbc_ram #(
		.W(DW),
		.D(2 * MAX_LENGTH)
	) u_tree_ram (
		.clk  (clk),
		.we   (tr_we),
		.waddr(tr_waddr),
		.wdata(tr_wdata),
		.raddr(tr_raddr),
		.rdata(tr_rdata)
	);

	brbc_ram #(
		.W(DW),
		.D(MAX_LENGTH + 1)
	) u_depth_ram (
		.clk  (clk),
		.we   (dep_we),
		.waddr(dep_waddr),
		.wdata(dep_wdata),
		.raddr(dep_raddr),
		.rdata(dep_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_q      <= '0;
			clr_idx_q   <= '0;
			tr_pend_q   <= 1'b0;
			db_pend_q   <= 1'b0;
			de_pend_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + TW'(1);
			end
			if (cmd.ld_leaf) begin
				count_q <= count_q + CW'(1);
				last_q  <= ld_val;
			end
			tr_pend_q   <= walk_rd;
			db_pend_q   <= cmd.dep_base;
			de_pend_q   <= cmd.dep_end;
			res_valid_q <= cmd.res_bad || cmd.res_eval;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_open_q <= item.is_open;
			x_q       <= item.range_start;
			y_q       <= item.range_end;
			l_q       <= l_init_w[LW-1:0];
			r_q       <= r_init_w[LW-1:0];
			m_q       <= DEPTH_MAX;
		end else begin
			if (tr_pend_q) begin
				m_q <= (tr_rd < m_q) ? tr_rd : m_q;
			end
			if (cmd.walk && !walk_done) begin
				if (l_q[0]) begin
					if (r_q[0]) begin
						l_q <= l_inc;
					end else begin
						l_q <= l_inc >> 1;
						r_q <= r_q >> 1;
					end
				end else if (r_q[0]) begin
					l_q <= l_q >> 1;
					r_q <= r_dec >> 1;
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
		end
		if (cmd.ld_leaf) begin
			cur_idx_q <= leaf_idx;
			cur_val_q <= ld_val;
		end else if (cmd.ld_up) begin
			cur_idx_q <= par_idx;
			cur_val_q <= up_val;
		end
		if (db_pend_q) begin
			base_q <= $signed(dep_rdata);
		end
		if (de_pend_q) begin
			end_q <= $signed(dep_rdata);
		end
		if (cmd.res_bad) begin
			res_q.balanced  <= 1'b0;
			res_q.bad_range <= 1'b1;
		end else if (cmd.res_eval) begin
			res_q.balanced  <= (x_q[0] != y_q[0]) && (end_q == base_q) && !(m_q < base_q);
			res_q.bad_range <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[design/bracket_range_balance_checker_unit.sv]
// Top level of the bracket range balance checker: controller, datapath and their wiring.
//
// One input channel: an item beat is taken at a rising edge with start high and busy low.
// A load beat (mode 0) appends one character, writes its prefix depth and walks the min
// tree from the leaf to the root, one sibling read and one parent write per level, while
// busy stays high. A load into a full text is dropped and leaves busy low.
// A query beat (mode 1) with a valid range reads both bounding depths from the depth memory
// while it walks the tree range with at most one tree memory read per cycle; busy stays
// high through the walk and the final evaluation step, and the result beat appears in the
// same cycle as busy falls. A query with a bad range gives its result in the next cycle and
// never raises busy.
// The result channel carries one beat per query, marked by result_valid for one cycle; the
// receiver cannot hold it off, so nothing waits on the output side.
// After reset busy stays high while the tree memory is swept to its maximum value and depth
// zero is written; no item is taken during that sweep.
module bracket_range_balance_checker_unit #(
	parameter int MAX_LENGTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  brbc_pkg::in_t  item,
	output logic           result_valid,
	output brbc_pkg::out_t result
);

	brbc_pkg::cmd_t cmd;
	brbc_pkg::sts_t sts;

	brbc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (item.mode),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	brbc_dp #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

[design/brbc_checker.sv]
// Port level checker for the bracket range balance checker and its bind to the top level.
`include "bracket_range_balance_checker_unit_macros.svh"

module brbc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input brbc_pkg::in_t  item,
	input logic           result_valid,
	input brbc_pkg::out_t result
);

	`BRBC_NEVER(a_flags_excl, clk, arst_n, result_valid && result.balanced && result.bad_range, "balanced and bad_range both set")
	`BRBC_ASSERT(a_load_silent, clk, arst_n, (start && !busy && !item.mode) |=> !result_valid, "load beat produced a result")
	`BRBC_ASSERT(a_res_cause, clk, arst_n, result_valid |-> $past(busy || (start && item.mode)), "result beat without a query")
	`BRBC_ASSERT(a_zero_start, clk, arst_n, (start && !busy && item.mode && (item.range_start == '0)) |=> (result_valid && result.bad_range), "zero range start not flagged")

endmodule

bind bracket_range_balance_checker_unit brbc_checker u_brbc_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the bracket range balance checker unit, with driver and monitor.
module tb;

	localparam int TEXT_CAP = 1024;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 40;
	localparam int CALM_TAIL = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	brbc_pkg::in_t item = '0;
	logic result_valid;
	brbc_pkg::out_t result;

	brbc_pkg::in_t pending[$];
	brbc_pkg::out_t verdicts[$];
	logic signed [11:0] depth_at [0:TEXT_CAP] = '{default: 12'sd0};
	int text_len = 0;
	int gen_depth [0:TEXT_CAP] = '{default: 0};
	int gen_len = 0;
	int run_left = 0;
	int run_bias = 50;
	int item_total = 0;
	int beats_taken = 0;
	int err_count = 0;
	int cycle_count = 0;
	int gap = 0;
	bit lively = 1'b1;
	logic taken = 1'b0;

	bracket_range_balance_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	always #6 clk = ~clk;

	task automatic absorb_item(input brbc_pkg::in_t it);
		brbc_pkg::out_t v;
		logic signed [11:0] base;
		logic signed [11:0] lowest;
		int x;
		int y;
		int p;
		x = int'(it.range_start);
		y = int'(it.range_end);
		if (it.mode == MODE_LOAD) begin
			if (text_len < TEXT_CAP) begin
				depth_at[text_len + 1] = it.is_open ? depth_at[text_len] + 12'sd1
					: depth_at[text_len] - 12'sd1;
				text_len++;
			end
		end else begin
			if (x == 0 || x > y || y > text_len) begin
				v = '{balanced: 1'b0, bad_range: 1'b1};
			end else begin
				base = depth_at[x - 1];
				lowest = depth_at[x];
				for (p = x + 1; p <= y; p++)
					if (depth_at[p] < lowest)
						lowest = depth_at[p];
				v.balanced = (((y - x + 1) % 2) == 0) && (depth_at[y] == base)
					&& (lowest >= base);
				v.bad_range = 1'b0;
			end
			verdicts.push_back(v);
		end
	endtask

	task automatic add_load(input bit open);
		brbc_pkg::in_t it;
		it.mode = MODE_LOAD;
		it.is_open = open;
		it.range_start = 11'($urandom_range(0, 2047));
		it.range_end = 11'($urandom_range(0, 2047));
		pending.push_back(it);
		if (gen_len < TEXT_CAP) begin
			gen_depth[gen_len + 1] = gen_depth[gen_len] + (open ? 1 : -1);
			gen_len++;
		end
	endtask

	task automatic add_query(input int x, input int y);
		brbc_pkg::in_t it;
		it.mode = MODE_QUERY;
		it.is_open = 1'($urandom_range(0, 1));
		it.range_start = 11'(x);
		it.range_end = 11'(y);
		pending.push_back(it);
	endtask

	task automatic add_random_load();
		if (run_left == 0) begin
			run_left = $urandom_range(1, 40);
			case ($urandom_range(0, 2))
				0: run_bias = 10;
				1: run_bias = 50;
				default: run_bias = 90;
			endcase
		end
		run_left--;
		add_load($urandom_range(0, 99) < run_bias);
	endtask

	task automatic add_random_query();
		int pick;
		int x;
		int y;
		int p;
		int base;
		int hits[$];
		pick = $urandom_range(0, 99);
		if (gen_len == 0 || pick >= 85) begin
			case ($urandom_range(0, 3))
				0: begin
					x = 0;
					y = $urandom_range(0, 2047);
				end
				1: begin
					x = $urandom_range(2, 2047);
					y = $urandom_range(1, x - 1);
				end
				2: begin
					x = $urandom_range(1, gen_len + 1);
					y = $urandom_range(gen_len + 1, 2047);
				end
				default: begin
					x = $urandom_range(0, 2047);
					y = $urandom_range(0, 2047);
				end
			endcase
		end else if (pick >= 55) begin
			x = $urandom_range(1, gen_len);
			y = $urandom_range(x, gen_len);
		end else begin
			x = $urandom_range(1, gen_len);
			base = gen_depth[x - 1];
			for (p = x; p <= gen_len && gen_depth[p] >= base; p++)
				if (gen_depth[p] == base)
					hits.push_back(p);
			if (hits.size() != 0)
				y = hits[$urandom_range(0, hits.size() - 1)];
			else
				y = $urandom_range(x, gen_len);
			if (pick >= 40)
				y = (y < gen_len) ? y + 1 : y - 1;
		end
		add_query(x, y);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			if (pending.size() < CALM_TAIL)
				lively = 1'b0;
			else if ($urandom_range(0, 39) == 0)
				lively = !lively;
			if (gap == 0 && lively && $urandom_range(0, 3) == 0)
				gap = $urandom_range(1, 14);
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending.size() != 0) begin
				item <= pending.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		brbc_pkg::out_t want;
		taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (result_valid) begin
				if (verdicts.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, got balanced %0b bad_range %0b",
						$time, result.balanced, result.bad_range);
					err_count++;
				end else begin
					want = verdicts.pop_front();
					if (result.balanced !== want.balanced) begin
						$display("%0t: balanced mismatch: expected %0b, got %0b",
							$time, want.balanced, result.balanced);
						err_count++;
					end
					if (result.bad_range !== want.bad_range) begin
						$display("%0t: bad_range mismatch: expected %0b, got %0b",
							$time, want.bad_range, result.bad_range);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				absorb_item(item);
				beats_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		add_query(1, 1);
		add_query(0, 0);
		add_load(1'b1);
		add_load(1'b0);
		add_query(1, 2);
		add_query(1, 1);
		add_query(2, 1);
		add_query(0, 2);
		add_query(1, 3);
		add_load(1'b0);
		add_load(1'b1);
		add_query(3, 4);
		add_query(2, 3);
		add_query(1, 4);
		add_query(2047, 2047);
		add_query(2047, 1);
		add_query(1, 2047);
		while (gen_len < TEXT_CAP) begin
			if ($urandom_range(0, 99) < 88)
				add_random_load();
			else
				add_random_query();
		end
		// The text is full here, so these loads must be dropped.
		repeat (6) add_random_load();
		add_query(1, TEXT_CAP);
		add_query(TEXT_CAP, TEXT_CAP);
		add_query(TEXT_CAP - 1, TEXT_CAP);
		add_query(1, TEXT_CAP + 1);
		repeat (20) add_random_query();
		add_load(1'b1);
		repeat (20) add_random_query();
		item_total = pending.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (beats_taken != item_total || verdicts.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
